### hdl/trio_mendelian_likelihood_ratio_unit_macros.svh
// Assertion macros shared by the trio likelihood-ratio unit.
// Define NO_ASSERTIONS to compile them away.
`ifndef TRIO_MENDELIAN_LIKELIHOOD_RATIO_UNIT_MACROS_SVH
`define TRIO_MENDELIAN_LIKELIHOOD_RATIO_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define TMLR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmlr: same-cycle check failed");
// Next-cycle implication
`define TMLR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmlr: next-cycle check failed");
`else
`define TMLR_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define TMLR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### hdl/tmlr_pkg.sv
package tmlr_pkg;

    localparam int NUM_GENO   = 10;
    localparam int GENO_IDX_W = 4;
    localparam int MEMBER_W   = 2;
    localparam int RATIO_W    = 10;
    localparam int LETTER_W   = 8;

    typedef logic [GENO_IDX_W-1:0] geno_idx_t;
    typedef logic [MEMBER_W-1:0]   member_t;
    typedef logic [NUM_GENO-1:0]   geno_set_t;
    typedef logic [3:0]            allele_set_t;
    typedef logic [LETTER_W-1:0]   letter_t;
    typedef logic [0:0]            cfg_index_t;

    localparam member_t MEMBER_CHILD  = 2'd0;
    localparam member_t MEMBER_FATHER = 2'd1;
    localparam member_t MEMBER_MOTHER = 2'd2;

    localparam cfg_index_t CFG_X_CHROMOSOME = 1'b0;
    localparam cfg_index_t CFG_MALE_CHILD   = 1'b1;

    localparam geno_idx_t LAST_GENO = geno_idx_t'(NUM_GENO - 1);
    localparam logic [RATIO_W-1:0] RATIO_MAX = '1;

    // Site settings seen by the sequencer
    typedef struct packed {
        logic x_chromosome;
        logic male_child;
    } site_cfg_t;

    // Read addresses into the three likelihood banks
    typedef struct packed {
        geno_idx_t child_idx;
        geno_idx_t father_idx;
        geno_idx_t mother_idx;
    } rd_addr_t;

    // Allele set of a genotype, bit order A C G T
    function automatic allele_set_t geno_mask(geno_idx_t g);
        allele_set_t m;
        case (g)
            4'd0:    m = 4'h1;
            4'd1:    m = 4'h3;
            4'd2:    m = 4'h5;
            4'd3:    m = 4'h9;
            4'd4:    m = 4'h2;
            4'd5:    m = 4'h6;
            4'd6:    m = 4'hA;
            4'd7:    m = 4'h4;
            4'd8:    m = 4'hC;
            4'd9:    m = 4'h8;
            default: m = 4'h0;
        endcase
        return m;
    endfunction

    // IUPAC letter of an allele set
    function automatic letter_t iupac(allele_set_t m);
        letter_t l;
        case (m)
            4'h0:    l = "X";
            4'h1:    l = "A";
            4'h2:    l = "C";
            4'h3:    l = "M";
            4'h4:    l = "G";
            4'h5:    l = "R";
            4'h6:    l = "S";
            4'h7:    l = "V";
            4'h8:    l = "T";
            4'h9:    l = "W";
            4'hA:    l = "Y";
            4'hB:    l = "H";
            4'hC:    l = "K";
            4'hD:    l = "D";
            4'hE:    l = "B";
            default: l = "N";
        endcase
        return l;
    endfunction

    // Child genotypes that agree with a father / mother pair
    function automatic geno_set_t child_set(geno_idx_t f, geno_idx_t m, site_cfg_t cfg);
        allele_set_t mf;
        allele_set_t mm;
        allele_set_t mc;
        geno_set_t   s;
        mf = geno_mask(f);
        mm = geno_mask(m);
        s  = '0;
        for (int c = 0; c < NUM_GENO; c++)
        begin
            mc = geno_mask(geno_idx_t'(c));
            if (cfg.x_chromosome && ($countones(mf) != 1))
                s[c] = 1'b0;
            else if (cfg.x_chromosome && cfg.male_child)
                s[c] = ($countones(mc) == 1) && ((mm & mc) != 4'h0);
            else
                s[c] = ((mf & mc) != 4'h0) && ((mm & mc) != 4'h0)
                       && (((mf | mm) & mc) == mc);
        end
        return s;
    endfunction

    // Index of the lowest set bit
    function automatic geno_idx_t lowest(geno_set_t s);
        geno_idx_t idx;
        idx = '0;
        for (int i = NUM_GENO - 1; i >= 0; i--)
        begin
            if (s[i])
                idx = geno_idx_t'(i);
        end
        return idx;
    endfunction

endpackage

### hdl/tmlr_store.sv
module tmlr_store #(
    parameter int LIKELIHOOD_BITS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  tmlr_pkg::member_t          wr_member,
    input  logic [LIKELIHOOD_BITS-1:0] wr_lik [tmlr_pkg::NUM_GENO],
    input  logic                       wr_ref_hom,
    input  tmlr_pkg::rd_addr_t         rd_addr,
    output logic [LIKELIHOOD_BITS-1:0] child_lik,
    output logic [LIKELIHOOD_BITS-1:0] father_lik,
    output logic [LIKELIHOOD_BITS-1:0] mother_lik,
    output logic                       all_ref_hom
);

    logic [LIKELIHOOD_BITS-1:0] child_bank_reg  [tmlr_pkg::NUM_GENO];
    logic [LIKELIHOOD_BITS-1:0] father_bank_reg [tmlr_pkg::NUM_GENO];
    logic [LIKELIHOOD_BITS-1:0] mother_bank_reg [tmlr_pkg::NUM_GENO];
    logic [2:0]                 ref_flags_reg;

    // Write a whole member's likelihoods in one go
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            case (wr_member)
                tmlr_pkg::MEMBER_CHILD:  child_bank_reg  <= wr_lik;
                tmlr_pkg::MEMBER_FATHER: father_bank_reg <= wr_lik;
                tmlr_pkg::MEMBER_MOTHER: mother_bank_reg <= wr_lik;
                default:                 ;
            endcase
        end
    end

    // Hold the reference-homozygous flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ref_flags_reg <= '0;
        else if (wr_en && (wr_member <= tmlr_pkg::MEMBER_MOTHER))
            ref_flags_reg[wr_member] <= wr_ref_hom;
    end

    // One read port per bank
    assign child_lik  = child_bank_reg[rd_addr.child_idx];
    assign father_lik = father_bank_reg[rd_addr.father_idx];
    assign mother_lik = mother_bank_reg[rd_addr.mother_idx];

    // No-call test for an arriving mother request
    assign all_ref_hom = ref_flags_reg[tmlr_pkg::MEMBER_CHILD]
                         & ref_flags_reg[tmlr_pkg::MEMBER_FATHER] & wr_ref_hom;

endmodule

### hdl/tmlr_alu.sv
module tmlr_alu #(
    parameter int WIDTH = 10
) (
    input  logic [WIDTH-1:0] x,
    input  logic [WIDTH-1:0] y,
    input  logic             sub,
    input  logic [WIDTH-1:0] cmp_val,
    output logic [WIDTH-1:0] res,
    output logic             less
);

    // Add or subtract, then compare against the running value
    assign res  = sub ? (x - y) : (x + y);
    assign less = (res < cmp_val);

endmodule

### hdl/tmlr_seq.sv
`include "trio_mendelian_likelihood_ratio_unit_macros.svh"

module tmlr_seq #(
    parameter int LIKELIHOOD_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  tmlr_pkg::site_cfg_t               cfg,
    input  logic                              mother_go,
    input  logic                              all_ref_hom,
    output logic                              busy,
    output tmlr_pkg::rd_addr_t                rd_addr,
    input  logic [LIKELIHOOD_BITS-1:0]        child_lik,
    input  logic [LIKELIHOOD_BITS-1:0]        father_lik,
    input  logic [LIKELIHOOD_BITS-1:0]        mother_lik,
    output logic [LIKELIHOOD_BITS+1:0]        alu_x,
    output logic [LIKELIHOOD_BITS+1:0]        alu_y,
    output logic                              alu_sub,
    output logic [LIKELIHOOD_BITS+1:0]        alu_cmp,
    input  logic [LIKELIHOOD_BITS+1:0]        alu_res,
    input  logic                              alu_less,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [tmlr_pkg::RATIO_W-1:0]      log_ratio,
    output logic                              no_call,
    output tmlr_pkg::letter_t                 child_letter,
    output tmlr_pkg::letter_t                 father_letter,
    output tmlr_pkg::letter_t                 mother_letter
);

    localparam int SW = LIKELIHOOD_BITS + 2;
    // Saturation bound; with no bits above the ratio field, all ones saturates to itself
    localparam logic [SW-1:0] RATIO_LIMIT = (SW > tmlr_pkg::RATIO_W)
                                            ? SW'(1 << tmlr_pkg::RATIO_W) : {SW{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIN,
        S_SUM1,
        S_SUM2,
        S_PAIR,
        S_TRIP,
        S_DIFF,
        S_DONE
    } state_t;

    state_t                         state_reg,  state_next;
    tmlr_pkg::member_t              scan_mem_reg, scan_mem_next;
    tmlr_pkg::geno_idx_t            scan_k_reg, scan_k_next;
    logic [LIKELIHOOD_BITS-1:0]     min_reg  [3];
    logic [LIKELIHOOD_BITS-1:0]     min_next [3];
    tmlr_pkg::geno_idx_t            arg_reg  [3];
    tmlr_pkg::geno_idx_t            arg_next [3];
    logic [SW-1:0]                  acc_reg, acc_next;
    logic [SW-1:0]                  best_reg, best_next;
    logic [SW-1:0]                  pairsum_reg, pairsum_next;
    tmlr_pkg::geno_idx_t            f_reg, f_next;
    tmlr_pkg::geno_idx_t            m_reg, m_next;
    tmlr_pkg::geno_set_t            cmask_reg, cmask_next;
    logic [tmlr_pkg::RATIO_W-1:0]   ratio_reg, ratio_next;
    logic                           nocall_pend_reg, nocall_pend_next;
    logic                           out_valid_reg, out_valid_next;
    logic [tmlr_pkg::RATIO_W-1:0]   log_ratio_reg, log_ratio_next;
    logic                           no_call_reg, no_call_next;
    tmlr_pkg::letter_t              child_letter_reg, child_letter_next;
    tmlr_pkg::letter_t              father_letter_reg, father_letter_next;
    tmlr_pkg::letter_t              mother_letter_reg, mother_letter_next;

    logic [LIKELIHOOD_BITS-1:0]     scan_lik;
    tmlr_pkg::geno_set_t            pair_set;
    tmlr_pkg::geno_idx_t            trip_c;
    tmlr_pkg::geno_set_t            cmask_left;
    logic                           last_pair;
    logic                           out_free;

    // Pick the bank under scan
    always_comb
    begin
        case (scan_mem_reg)
            tmlr_pkg::MEMBER_CHILD:  scan_lik = child_lik;
            tmlr_pkg::MEMBER_FATHER: scan_lik = father_lik;
            default:                 scan_lik = mother_lik;
        endcase
    end

    assign pair_set   = tmlr_pkg::child_set(f_reg, m_reg, cfg);
    assign trip_c     = tmlr_pkg::lowest(cmask_reg);
    assign cmask_left = cmask_reg & (cmask_reg - 1'b1);
    assign last_pair  = (f_reg == tmlr_pkg::LAST_GENO) && (m_reg == tmlr_pkg::LAST_GENO);
    assign out_free   = !out_valid_reg || !out_stall;

    // Sequencer: next state, read addresses and shared unit operands
    always_comb
    begin
        state_next         = state_reg;
        scan_mem_next      = scan_mem_reg;
        scan_k_next        = scan_k_reg;
        min_next           = min_reg;
        arg_next           = arg_reg;
        acc_next           = acc_reg;
        best_next          = best_reg;
        pairsum_next       = pairsum_reg;
        f_next             = f_reg;
        m_next             = m_reg;
        cmask_next         = cmask_reg;
        ratio_next         = ratio_reg;
        nocall_pend_next   = nocall_pend_reg;
        out_valid_next     = out_valid_reg && out_stall;
        log_ratio_next     = log_ratio_reg;
        no_call_next       = no_call_reg;
        child_letter_next  = child_letter_reg;
        father_letter_next = father_letter_reg;
        mother_letter_next = mother_letter_reg;

        rd_addr = '{child_idx: trip_c, father_idx: f_reg, mother_idx: m_reg};
        alu_x   = '0;
        alu_y   = '0;
        alu_sub = 1'b0;
        alu_cmp = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (mother_go)
                begin
                    nocall_pend_next = all_ref_hom;
                    scan_mem_next    = tmlr_pkg::MEMBER_CHILD;
                    scan_k_next      = '0;
                    state_next       = all_ref_hom ? S_DONE : S_MIN;
                end
            end

            // Walk each member's likelihoods for its minimum, first index on ties
            S_MIN:
            begin
                rd_addr = '{child_idx: scan_k_reg, father_idx: scan_k_reg,
                            mother_idx: scan_k_reg};
                alu_x   = SW'(scan_lik);
                alu_cmp = SW'(min_reg[scan_mem_reg]);
                if ((scan_k_reg == '0) || alu_less)
                begin
                    min_next[scan_mem_reg] = scan_lik;
                    arg_next[scan_mem_reg] = scan_k_reg;
                end
                if (scan_k_reg == tmlr_pkg::LAST_GENO)
                begin
                    scan_k_next = '0;
                    if (scan_mem_reg == tmlr_pkg::MEMBER_MOTHER)
                        state_next = S_SUM1;
                    else
                        scan_mem_next = scan_mem_reg + 1'b1;
                end
                else
                    scan_k_next = scan_k_reg + 1'b1;
            end

            S_SUM1:
            begin
                alu_x      = SW'(min_reg[0]);
                alu_y      = SW'(min_reg[1]);
                acc_next   = alu_res;
                state_next = S_SUM2;
            end

            S_SUM2:
            begin
                alu_x      = acc_reg;
                alu_y      = SW'(min_reg[2]);
                acc_next   = alu_res;
                best_next  = '1;
                f_next     = '0;
                m_next     = '0;
                state_next = S_PAIR;
            end

            // Load a parent pair: its sum and the set of children it allows
            S_PAIR:
            begin
                alu_x = SW'(father_lik);
                alu_y = SW'(mother_lik);
                if (pair_set != '0)
                begin
                    pairsum_next = alu_res;
                    cmask_next   = pair_set;
                    state_next   = S_TRIP;
                end
                else if (last_pair)
                    state_next = S_DIFF;
                else if (m_reg == tmlr_pkg::LAST_GENO)
                begin
                    f_next = f_reg + 1'b1;
                    m_next = '0;
                end
                else
                    m_next = m_reg + 1'b1;
            end

            // One consistent child per cycle against the running best
            S_TRIP:
            begin
                alu_x      = SW'(child_lik);
                alu_y      = pairsum_reg;
                alu_cmp    = best_reg;
                cmask_next = cmask_left;
                if (alu_less)
                    best_next = alu_res;
                if (cmask_left == '0)
                begin
                    if (last_pair)
                        state_next = S_DIFF;
                    else
                    begin
                        state_next = S_PAIR;
                        if (m_reg == tmlr_pkg::LAST_GENO)
                        begin
                            f_next = f_reg + 1'b1;
                            m_next = '0;
                        end
                        else
                            m_next = m_reg + 1'b1;
                    end
                end
            end

            // Subtract the minima and saturate
            S_DIFF:
            begin
                alu_x      = best_reg;
                alu_y      = acc_reg;
                alu_sub    = 1'b1;
                alu_cmp    = RATIO_LIMIT;
                ratio_next = alu_less ? alu_res[tmlr_pkg::RATIO_W-1:0] : tmlr_pkg::RATIO_MAX;
                state_next = S_DONE;
            end

            // Hand the result to the output register once it is free
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    no_call_next   = nocall_pend_reg;
                    if (nocall_pend_reg)
                    begin
                        log_ratio_next     = '0;
                        child_letter_next  = '0;
                        father_letter_next = '0;
                        mother_letter_next = '0;
                    end
                    else
                    begin
                        log_ratio_next     = ratio_reg;
                        child_letter_next  = tmlr_pkg::iupac(tmlr_pkg::geno_mask(arg_reg[0]));
                        father_letter_next = tmlr_pkg::iupac(tmlr_pkg::geno_mask(arg_reg[1]));
                        mother_letter_next = tmlr_pkg::iupac(tmlr_pkg::geno_mask(arg_reg[2]));
                    end
                    state_next = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            scan_mem_reg      <= tmlr_pkg::MEMBER_CHILD;
            scan_k_reg        <= '0;
            for (int i = 0; i < 3; i++)
            begin
                min_reg[i] <= '0;
                arg_reg[i] <= '0;
            end
            acc_reg           <= '0;
            best_reg          <= '0;
            pairsum_reg       <= '0;
            f_reg             <= '0;
            m_reg             <= '0;
            cmask_reg         <= '0;
            ratio_reg         <= '0;
            nocall_pend_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
            log_ratio_reg     <= '0;
            no_call_reg       <= 1'b0;
            child_letter_reg  <= '0;
            father_letter_reg <= '0;
            mother_letter_reg <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            scan_mem_reg      <= scan_mem_next;
            scan_k_reg        <= scan_k_next;
            min_reg           <= min_next;
            arg_reg           <= arg_next;
            acc_reg           <= acc_next;
            best_reg          <= best_next;
            pairsum_reg       <= pairsum_next;
            f_reg             <= f_next;
            m_reg             <= m_next;
            cmask_reg         <= cmask_next;
            ratio_reg         <= ratio_next;
            nocall_pend_reg   <= nocall_pend_next;
            out_valid_reg     <= out_valid_next;
            log_ratio_reg     <= log_ratio_next;
            no_call_reg       <= no_call_next;
            child_letter_reg  <= child_letter_next;
            father_letter_reg <= father_letter_next;
            mother_letter_reg <= mother_letter_next;
        end
    end

    assign busy          = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign log_ratio     = log_ratio_reg;
    assign no_call       = no_call_reg;
    assign child_letter  = child_letter_reg;
    assign father_letter = father_letter_reg;
    assign mother_letter = mother_letter_reg;

    `TMLR_ASSERT_NEXT(a_mother_starts_run, clk, rst_n, mother_go, state_reg != S_IDLE)
    `TMLR_ASSERT_IMP(a_trip_has_child, clk, rst_n, state_reg == S_TRIP, cmask_reg != '0)
    `TMLR_ASSERT_IMP(a_best_above_minima, clk, rst_n, state_reg == S_DIFF, best_reg >= acc_reg)
    `TMLR_ASSERT_IMP(a_no_call_blank, clk, rst_n, out_valid_reg && no_call_reg, log_ratio_reg == '0 && child_letter_reg == '0 && father_letter_reg == '0 && mother_letter_reg == '0)

endmodule

### hdl/trio_mendelian_likelihood_ratio_unit.sv
// Trio Mendelian likelihood-ratio unit. Child and father requests are stored as they are
// accepted; the mother request starts a run on one shared adder-comparator: find each
// member's minimum and best genotype, sum the minima, then step through every father/mother
// pair plus each Mendelian-consistent child of that pair, then subtract and post the
// result. A no-call (all three members reference homozygous) skips the run and goes
// straight to posting its result. Posting waits while an earlier result is still held in
// the output register. The input is stalled while a run is in progress; the result waits
// in an output register, so child and father requests for the next trio can follow at once.
module trio_mendelian_likelihood_ratio_unit #(
    parameter int LIKELIHOOD_BITS = 8
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  tmlr_pkg::cfg_index_t         cfg_index,
    input  logic                         cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  tmlr_pkg::member_t            member,
    input  logic [LIKELIHOOD_BITS-1:0]   lik_0,
    input  logic [LIKELIHOOD_BITS-1:0]   lik_1,
    input  logic [LIKELIHOOD_BITS-1:0]   lik_2,
    input  logic [LIKELIHOOD_BITS-1:0]   lik_3,
    input  logic [LIKELIHOOD_BITS-1:0]   lik_4,
    input  logic [LIKELIHOOD_BITS-1:0]   lik_5,
    input  logic [LIKELIHOOD_BITS-1:0]   lik_6,
    input  logic [LIKELIHOOD_BITS-1:0]   lik_7,
    input  logic [LIKELIHOOD_BITS-1:0]   lik_8,
    input  logic [LIKELIHOOD_BITS-1:0]   lik_9,
    input  logic                         ref_hom_best,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [tmlr_pkg::RATIO_W-1:0] log_ratio,
    output logic                         no_call,
    output tmlr_pkg::letter_t            child_letter,
    output tmlr_pkg::letter_t            father_letter,
    output tmlr_pkg::letter_t            mother_letter
);

    localparam int SW = LIKELIHOOD_BITS + 2;

    logic                       x_chromosome_reg;
    logic                       male_child_reg;
    tmlr_pkg::site_cfg_t        site_cfg;
    logic                       busy;
    logic                       in_accept;
    logic                       mother_go;
    logic                       all_ref_hom;
    logic [LIKELIHOOD_BITS-1:0] wr_lik [tmlr_pkg::NUM_GENO];
    tmlr_pkg::rd_addr_t         rd_addr;
    logic [LIKELIHOOD_BITS-1:0] child_lik;
    logic [LIKELIHOOD_BITS-1:0] father_lik;
    logic [LIKELIHOOD_BITS-1:0] mother_lik;
    logic [SW-1:0]              alu_x;
    logic [SW-1:0]              alu_y;
    logic                       alu_sub;
    logic [SW-1:0]              alu_cmp;
    logic [SW-1:0]              alu_res;
    logic                       alu_less;

    // Site settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_chromosome_reg <= 1'b0;
            male_child_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                tmlr_pkg::CFG_X_CHROMOSOME: x_chromosome_reg <= cfg_data;
                tmlr_pkg::CFG_MALE_CHILD:   male_child_reg   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign site_cfg = '{x_chromosome: x_chromosome_reg, male_child: male_child_reg};

    // Accept requests only between runs
    assign in_stall  = busy;
    assign in_accept = in_valid && !busy;
    assign mother_go = in_accept && (member == tmlr_pkg::MEMBER_MOTHER);

    assign wr_lik[0] = lik_0;
    assign wr_lik[1] = lik_1;
    assign wr_lik[2] = lik_2;
    assign wr_lik[3] = lik_3;
    assign wr_lik[4] = lik_4;
    assign wr_lik[5] = lik_5;
    assign wr_lik[6] = lik_6;
    assign wr_lik[7] = lik_7;
    assign wr_lik[8] = lik_8;
    assign wr_lik[9] = lik_9;

    tmlr_store #(
        .LIKELIHOOD_BITS (LIKELIHOOD_BITS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (in_accept),
        .wr_member   (member),
        .wr_lik      (wr_lik),
        .wr_ref_hom  (ref_hom_best),
        .rd_addr     (rd_addr),
        .child_lik   (child_lik),
        .father_lik  (father_lik),
        .mother_lik  (mother_lik),
        .all_ref_hom (all_ref_hom)
    );

    tmlr_alu #(
        .WIDTH (SW)
    ) u_alu (
        .x       (alu_x),
        .y       (alu_y),
        .sub     (alu_sub),
        .cmp_val (alu_cmp),
        .res     (alu_res),
        .less    (alu_less)
    );

    tmlr_seq #(
        .LIKELIHOOD_BITS (LIKELIHOOD_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (site_cfg),
        .mother_go     (mother_go),
        .all_ref_hom   (all_ref_hom),
        .busy          (busy),
        .rd_addr       (rd_addr),
        .child_lik     (child_lik),
        .father_lik    (father_lik),
        .mother_lik    (mother_lik),
        .alu_x         (alu_x),
        .alu_y         (alu_y),
        .alu_sub       (alu_sub),
        .alu_cmp       (alu_cmp),
        .alu_res       (alu_res),
        .alu_less      (alu_less),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .log_ratio     (log_ratio),
        .no_call       (no_call),
        .child_letter  (child_letter),
        .father_letter (father_letter),
        .mother_letter (mother_letter)
    );

endmodule
